/* rtl/arc_ring_row_span_generator_macros.svh */
// Assertion macros used by the top RTL file of the arc span generator.
`ifndef ARC_RING_ROW_SPAN_GENERATOR_MACROS_SVH
`define ARC_RING_ROW_SPAN_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ARSG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ARSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARSG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ARSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/arsg_pkg.sv */
package arsg_pkg;

    localparam int MAX_RADIUS  = 127;
    localparam int SCREEN_SIZE = 512;
    localparam int HALF_Q14    = 8192;
    localparam int MAX_SPANS   = 4;
    localparam int SPAN_IDX_W  = $clog2(MAX_SPANS);
    localparam int SPAN_CNT_W  = $clog2(MAX_SPANS + 1);

    localparam logic [11:0] ANG_90  = 12'd900;
    localparam logic [11:0] ANG_180 = 12'd1800;
    localparam logic [11:0] ANG_270 = 12'd2700;
    localparam logic [11:0] ANG_360 = 12'd3600;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SKIP,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        REG_CENTER_XY,
        REG_OUTER_RADIUS,
        REG_INNER_RADIUS,
        REG_START_ANGLE,
        REG_END_ANGLE,
        REG_START_TRIG,
        REG_END_TRIG,
        REG_FILL_COLOR
    } t_cfg_reg;

    typedef enum logic [2:0] {
        MS_YY,
        MS_OO,
        MS_II,
        MS_YCS,
        MS_YCE,
        MS_XSS,
        MS_XSE
    } t_mul_step;

    typedef struct packed {
        logic [8:0]         cx;
        logic [8:0]         cy;
        logic [6:0]         orad;
        logic [6:0]         ir;
        logic               rev;
        logic               s180;
        logic               e180;
        logic               xs_zero;
        logic               xe_one;
        logic               ylo_zero;
        logic               yhi_zero;
        logic signed [15:0] cs;
        logic signed [15:0] ss;
        logic signed [15:0] ce;
        logic signed [15:0] se;
        logic [15:0]        color;
    } t_geom;

    function automatic logic [11:0] nudge(input logic [11:0] a);
        if (a == ANG_90 || a == ANG_180 || a == ANG_270 || a == ANG_360) begin
            return a - 12'd1;
        end
        return a;
    endfunction

    function automatic logic [6:0] clamp_radius(input logic [6:0] r);
        if (r == 7'd0) begin
            return 7'd1;
        end
        if ({25'd0, r} > MAX_RADIUS) begin
            return 7'(MAX_RADIUS);
        end
        return r;
    endfunction

endpackage

/* rtl/arsg_cfg.sv */
module arsg_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_wdata,
    output arsg_pkg::t_geom      o_geom
);

    logic [17:0] r_center;
    logic [6:0]  r_outer;
    logic [6:0]  r_inner;
    logic [11:0] r_start;
    logic [11:0] r_end;
    logic [31:0] r_start_trig;
    logic [31:0] r_end_trig;
    logic [15:0] r_color;

    logic [6:0]  w_r_hi;
    logic [6:0]  w_r_lo;
    logic [11:0] w_st;
    logic [11:0] w_en;
    logic [12:0] w_st13;
    logic [12:0] w_en13;
    logic        w_rev;
    logic        w_st_side;
    logic        w_en_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center     <= 18'd0;
            r_outer      <= 7'd1;
            r_inner      <= 7'd1;
            r_start      <= 12'd0;
            r_end        <= arsg_pkg::ANG_360;
            r_start_trig <= 32'h4000_0000;
            r_end_trig   <= 32'h4000_FFE3;
            r_color      <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (arsg_pkg::t_cfg_reg'(i_cfg_index))
                arsg_pkg::REG_CENTER_XY:    r_center     <= i_cfg_wdata[17:0];
                arsg_pkg::REG_OUTER_RADIUS: r_outer      <= i_cfg_wdata[6:0];
                arsg_pkg::REG_INNER_RADIUS: r_inner      <= i_cfg_wdata[6:0];
                arsg_pkg::REG_START_ANGLE:  r_start      <= i_cfg_wdata[11:0];
                arsg_pkg::REG_END_ANGLE:    r_end        <= i_cfg_wdata[11:0];
                arsg_pkg::REG_START_TRIG:   r_start_trig <= i_cfg_wdata;
                arsg_pkg::REG_END_TRIG:     r_end_trig   <= i_cfg_wdata;
                arsg_pkg::REG_FILL_COLOR:   r_color      <= i_cfg_wdata[15:0];
            endcase
        end
    end

    assign w_r_hi = (r_outer < r_inner) ? r_inner : r_outer;
    assign w_r_lo = (r_outer < r_inner) ? r_outer : r_inner;
    assign w_st   = arsg_pkg::nudge(r_start);
    assign w_en   = arsg_pkg::nudge(r_end);
    assign w_st13 = {1'b0, w_st};
    assign w_en13 = {1'b0, w_en};

    assign w_rev = (w_st13 + {1'b0, arsg_pkg::ANG_180} < w_en13)
                || ((w_en < w_st) && (w_st13 < w_en13 + {1'b0, arsg_pkg::ANG_180}));

    assign w_st_side = (w_st >= arsg_pkg::ANG_270) || (w_st < arsg_pkg::ANG_90);
    assign w_en_side = (w_en >= arsg_pkg::ANG_270) || (w_en < arsg_pkg::ANG_90);

    always_comb begin
        o_geom.cx       = 9'(r_center / 18'(arsg_pkg::SCREEN_SIZE));
        o_geom.cy       = 9'(r_center % 18'(arsg_pkg::SCREEN_SIZE));
        o_geom.orad     = arsg_pkg::clamp_radius(w_r_hi);
        o_geom.ir       = arsg_pkg::clamp_radius(w_r_lo) - 7'd1;
        o_geom.rev      = w_rev;
        o_geom.s180     = (w_st >= arsg_pkg::ANG_180);
        o_geom.e180     = (w_en < arsg_pkg::ANG_180);
        o_geom.xs_zero  = !w_rev && w_st_side && w_en_side;
        o_geom.xe_one   = !w_rev && !w_st_side && !w_en_side;
        o_geom.yhi_zero = !w_rev && (w_en >= arsg_pkg::ANG_180) && (w_st >= arsg_pkg::ANG_180);
        o_geom.ylo_zero = !w_rev && (w_en < arsg_pkg::ANG_180) && (w_st < arsg_pkg::ANG_180);
        o_geom.cs       = $signed(r_start_trig[31:16]);
        o_geom.ss       = $signed(r_start_trig[15:0]);
        o_geom.ce       = $signed(r_end_trig[31:16]);
        o_geom.se       = $signed(r_end_trig[15:0]);
        o_geom.color    = r_color;
    end

endmodule

/* rtl/arc_ring_row_span_generator.sv */
// Setup: an accepted row in range is prepared with seven products on the one shared
// multiplier, then skips one column a cycle outside the ring and scans one column a cycle.
// A new row is taken only in idle, once all spans of the previous row are loaded for output.
// Spans leave from a buffer of four, one word a cycle while the output side is ready.
// Reset: synchronous, active low; control and configuration registers take their reset values and the block idles.
`include "arc_ring_row_span_generator_macros.svh"

module arc_ring_row_span_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // row_offset[7:0]
    input  logic [7:0]  i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // span_x[10:0], span_y[21:11], span_length[30:22], span_color[46:31], zero[47]
    output logic [47:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam int SIW = arsg_pkg::SPAN_IDX_W;
    localparam int SCW = arsg_pkg::SPAN_CNT_W;

    arsg_pkg::t_geom w_geom;

    arsg_pkg::t_state    r_state, n_state;
    arsg_pkg::t_mul_step r_step, n_step;

    logic signed [7:0]  r_y, n_y;
    logic [10:0]        r_span_y, n_span_y;
    logic [16:0]        r_y2, n_y2;
    logic [16:0]        r_or2, n_or2;
    logic [16:0]        r_ir2, n_ir2;
    logic [16:0]        r_xx, n_xx;
    logic signed [25:0] r_qs, n_qs;
    logic signed [25:0] r_qe, n_qe;
    logic signed [25:0] r_ps, n_ps;
    logic signed [25:0] r_pe, n_pe;
    logic signed [9:0]  r_x, n_x;
    logic signed [9:0]  r_xe, n_xe;
    logic [8:0]         r_len, n_len;
    logic [SCW-1:0]     r_n, n_n;
    logic [SIW-1:0]     r_k, n_k;

    logic [10:0] r_buf_x   [arsg_pkg::MAX_SPANS];
    logic [8:0]  r_buf_len [arsg_pkg::MAX_SPANS];

    logic        r_out_valid, n_out_valid;
    logic [10:0] r_out_x, n_out_x;
    logic [10:0] r_out_y, n_out_y;
    logic [8:0]  r_out_len, n_out_len;
    logic [15:0] r_out_color, n_out_color;
    logic        r_out_last, n_out_last;

    logic               w_accept;
    logic signed [7:0]  w_y_in;
    logic signed [8:0]  w_y9;
    logic signed [8:0]  w_orad9;
    logic               w_row_ok;
    logic signed [9:0]  w_xs;
    logic signed [15:0] w_mul_a;
    logic signed [9:0]  w_mul_b;
    logic signed [25:0] w_prod;
    logic [16:0]        w_d;
    logic               w_below_s;
    logic               w_below_e;
    logic               w_f1;
    logic               w_f2;
    logic               w_inside;
    logic               w_flip;
    logic               w_stop;
    logic signed [9:0]  w_x1;
    logic signed [25:0] w_ps1;
    logic signed [25:0] w_pe1;
    logic signed [9:0]  w_xn;
    logic [16:0]        w_xxn;
    logic signed [25:0] w_psn;
    logic signed [25:0] w_pen;
    logic               w_xn_past;
    logic               w_skip_more;
    logic               w_buf_we;
    logic [10:0]        w_buf_x;
    logic [SCW-1:0]     w_n_after;
    logic               w_out_load;
    logic               w_last_k;

    arsg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (w_geom)
    );

    assign o_s_axis_tready = (r_state == arsg_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_y_in          = $signed(i_s_axis_tdata);
    assign w_y9            = {w_y_in[7], w_y_in};
    assign w_orad9         = $signed({2'b00, w_geom.orad});
    assign w_row_ok        = (w_geom.ylo_zero ? !w_y9[8] : (w_y9 >= -w_orad9))
                          && (w_geom.yhi_zero ? (w_y9 <= 9'sd0) : (w_y9 <= w_orad9));
    assign w_xs            = w_geom.xs_zero ? 10'sd0 : -$signed({3'b000, w_geom.orad});

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_step)
            arsg_pkg::MS_YY: begin
                w_mul_a = {{8{r_y[7]}}, r_y};
                w_mul_b = {{2{r_y[7]}}, r_y};
            end
            arsg_pkg::MS_OO: begin
                w_mul_a = $signed({9'd0, w_geom.orad});
                w_mul_b = $signed({3'd0, w_geom.orad});
            end
            arsg_pkg::MS_II: begin
                w_mul_a = $signed({9'd0, w_geom.ir});
                w_mul_b = $signed({3'd0, w_geom.ir});
            end
            arsg_pkg::MS_YCS: begin
                w_mul_a = w_geom.cs;
                w_mul_b = {{2{r_y[7]}}, r_y};
            end
            arsg_pkg::MS_YCE: begin
                w_mul_a = w_geom.ce;
                w_mul_b = {{2{r_y[7]}}, r_y};
            end
            arsg_pkg::MS_XSS: begin
                w_mul_a = w_geom.ss;
                w_mul_b = r_x;
            end
            arsg_pkg::MS_XSE: begin
                w_mul_a = w_geom.se;
                w_mul_b = r_x;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_d       = r_xx + r_y2;
    assign w_below_s = w_geom.ss[15] ? (r_ps >= r_qs) : (r_ps <= r_qs);
    assign w_below_e = w_geom.se[15] ? (r_pe >= r_qe) : (r_pe <= r_qe);
    assign w_f1      = w_geom.s180 ^ w_below_s;
    assign w_f2      = w_geom.e180 ^ w_below_e;
    assign w_inside  = (w_d >= r_ir2) && ((w_f1 && w_f2) || (w_geom.rev && (w_f1 || w_f2)))
                    && (r_x != r_xe) && (w_d < r_or2);
    assign w_flip    = (r_state == arsg_pkg::ST_SCAN) && !w_inside && r_x[9] && (w_d < r_ir2);
    assign w_stop    = !w_inside && (w_d >= r_or2);
    assign w_x1      = w_flip ? -r_x : r_x;
    assign w_ps1     = w_flip ? -r_ps : r_ps;
    assign w_pe1     = w_flip ? -r_pe : r_pe;
    assign w_xn      = w_x1 + 10'sd1;
    assign w_xxn     = r_xx + {{6{w_x1[9]}}, w_x1, 1'b1};
    assign w_psn     = w_ps1 + 26'(w_geom.ss);
    assign w_pen     = w_pe1 + 26'(w_geom.se);
    assign w_xn_past = (w_xn > r_xe);
    assign w_skip_more = r_x[9] && (w_d >= r_or2);

    assign w_buf_we  = (r_state == arsg_pkg::ST_SCAN) && !w_inside && (r_len != 9'd0)
                    && (r_n < SCW'(arsg_pkg::MAX_SPANS));
    assign w_buf_x   = {2'b00, w_geom.cx} + {r_x[9], r_x} - {2'b00, r_len};
    assign w_n_after = r_n + SCW'(w_buf_we);

    assign w_out_load = (r_state == arsg_pkg::ST_EMIT) && (!r_out_valid || i_m_axis_tready);
    assign w_last_k   = (SCW'(r_k) == r_n - SCW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arsg_pkg::ST_IDLE: begin
                if (w_accept && w_row_ok) begin
                    n_state = arsg_pkg::ST_MUL;
                end
            end
            arsg_pkg::ST_MUL: begin
                if (r_step == arsg_pkg::MS_XSE) begin
                    n_state = arsg_pkg::ST_SKIP;
                end
            end
            arsg_pkg::ST_SKIP: begin
                if (!w_skip_more) begin
                    n_state = arsg_pkg::ST_SCAN;
                end
            end
            arsg_pkg::ST_SCAN: begin
                if (w_stop || w_xn_past) begin
                    n_state = (w_n_after != '0) ? arsg_pkg::ST_EMIT : arsg_pkg::ST_IDLE;
                end
            end
            arsg_pkg::ST_EMIT: begin
                if (w_out_load && w_last_k) begin
                    n_state = arsg_pkg::ST_IDLE;
                end
            end
            default: n_state = arsg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_step      = r_step;
        n_y         = r_y;
        n_span_y    = r_span_y;
        n_y2        = r_y2;
        n_or2       = r_or2;
        n_ir2       = r_ir2;
        n_xx        = r_xx;
        n_qs        = r_qs;
        n_qe        = r_qe;
        n_ps        = r_ps;
        n_pe        = r_pe;
        n_x         = r_x;
        n_xe        = r_xe;
        n_len       = r_len;
        n_n         = r_n;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_len   = r_out_len;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;
        unique case (r_state)
            arsg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_y      = w_y_in;
                    n_span_y = {2'b00, w_geom.cy} + {{3{w_y_in[7]}}, w_y_in};
                    n_x      = w_xs;
                    n_step   = arsg_pkg::MS_YY;
                    n_len    = '0;
                    n_n      = '0;
                    n_k      = '0;
                end
            end
            arsg_pkg::ST_MUL: begin
                n_step = arsg_pkg::t_mul_step'(r_step + 3'd1);
                unique case (r_step)
                    arsg_pkg::MS_YY:  n_y2 = w_prod[16:0];
                    arsg_pkg::MS_OO: begin
                        n_or2 = w_prod[16:0] + {10'd0, w_geom.orad};
                        n_xx  = w_geom.xs_zero ? 17'd0 : w_prod[16:0];
                    end
                    arsg_pkg::MS_II:  n_ir2 = w_prod[16:0] + {10'd0, w_geom.ir};
                    arsg_pkg::MS_YCS: n_qs  = w_prod + 26'(arsg_pkg::HALF_Q14);
                    arsg_pkg::MS_YCE: n_qe  = w_prod - 26'(arsg_pkg::HALF_Q14);
                    arsg_pkg::MS_XSS: n_ps  = w_prod;
                    arsg_pkg::MS_XSE: n_pe  = w_prod;
                    default:          n_step = r_step;
                endcase
            end
            arsg_pkg::ST_SKIP: begin
                if (w_skip_more) begin
                    n_x  = w_xn;
                    n_xx = w_xxn;
                    n_ps = w_psn;
                    n_pe = w_pen;
                end else if (w_geom.xe_one) begin
                    n_xe = 10'sd1;
                end else if (!w_geom.xs_zero) begin
                    n_xe = 10'sd1 - r_x;
                end else begin
                    n_xe = $signed({3'b000, w_geom.orad}) + 10'sd1;
                end
            end
            arsg_pkg::ST_SCAN: begin
                n_len = w_inside ? r_len + 9'd1 : 9'd0;
                n_n   = w_n_after;
                n_x   = w_xn;
                n_xx  = w_xxn;
                n_ps  = w_psn;
                n_pe  = w_pen;
            end
            arsg_pkg::ST_EMIT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_x     = r_buf_x[r_k];
                    n_out_y     = r_span_y;
                    n_out_len   = r_buf_len[r_k];
                    n_out_color = w_geom.color;
                    n_out_last  = w_last_k;
                    n_k         = r_k + SIW'(1);
                end
            end
            default: n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arsg_pkg::ST_IDLE;
            r_step      <= arsg_pkg::MS_YY;
            r_len       <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_len       <= n_len;
            r_n         <= n_n;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y         <= n_y;
        r_span_y    <= n_span_y;
        r_y2        <= n_y2;
        r_or2       <= n_or2;
        r_ir2       <= n_ir2;
        r_xx        <= n_xx;
        r_qs        <= n_qs;
        r_qe        <= n_qe;
        r_ps        <= n_ps;
        r_pe        <= n_pe;
        r_x         <= n_x;
        r_xe        <= n_xe;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_len   <= n_out_len;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf_x[r_n[SIW-1:0]]   <= w_buf_x;
            r_buf_len[r_n[SIW-1:0]] <= r_len;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_color, r_out_len, r_out_y, r_out_x};
    assign o_m_axis_tlast  = r_out_last;

    `ARSG_ASSERT_IMP(a_span_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, r_out_len != 9'd0, "span word of zero length")
    `ARSG_ASSERT_IMP(a_span_count, i_clk, i_rst_n, r_state == arsg_pkg::ST_SCAN, r_n <= SCW'(arsg_pkg::MAX_SPANS), "span buffer overrun")
    `ARSG_ASSERT_IMP(a_emit_index, i_clk, i_rst_n, r_state == arsg_pkg::ST_EMIT, SCW'(r_k) < r_n, "span read beyond those stored")
    `ARSG_ASSERT_NEXT(a_row_start, i_clk, i_rst_n, w_accept && w_row_ok, r_state == arsg_pkg::ST_MUL && r_step == arsg_pkg::MS_YY, "accepted row did not start setup")

endmodule

/* dv/tb_arc_ring_row_span_generator.sv */
`timescale 1ns / 100ps

module tb_arc_ring_row_span_generator;
    import arsg_pkg::*;

    localparam int SETTLE      = 450;
    localparam int QUIET_LIMIT = 5000;
    localparam int DIR_LEN     = 25;
    localparam int PHASES      = 9;
    localparam int PHASE_ROWS  = 40;

    typedef struct packed {
        logic [10:0] sx;
        logic [10:0] sy;
        logic [8:0]  len;
        logic [15:0] color;
        logic        last;
    } span_t;

    typedef struct packed {
        logic [17:0] center;
        logic [6:0]  rad_a;
        logic [6:0]  rad_b;
        logic [11:0] ang_s;
        logic [11:0] ang_e;
        logic [31:0] trig_s;
        logic [31:0] trig_e;
        logic [15:0] color;
    } setting_t;

    typedef enum logic [1:0] {
        DIR_CFG,
        DIR_ROW,
        DIR_ROW_KNOWN
    } dir_kind_t;

    typedef struct packed {
        dir_kind_t   kind;
        logic [1:0]  set_idx;
        logic [7:0]  row;
        logic        has_span;
        span_t       span;
    } dir_entry_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    setting_t cur;
    span_t    pending_spans [$];
    span_t    got;
    span_t    want;
    bit       gaps_on;
    int       errors;
    int       quiet;
    int       stall_left;
    int       rows_sent;
    int       spans_seen;
    int       settings_used;

    arc_ring_row_span_generator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Angles on a quarter boundary are pulled back by one tenth of a degree.
    function automatic logic [11:0] angle_adj(input logic [11:0] a);
        if (a == ANG_90 || a == ANG_180 || a == ANG_270 || a == ANG_360) begin
            return a - 12'd1;
        end
        return a;
    endfunction

    function automatic longint radius_lim(input logic [6:0] r);
        if (r == 7'd0) begin
            return 1;
        end
        if (longint'(r) > MAX_RADIUS) begin
            return MAX_RADIUS;
        end
        return longint'(r);
    endfunction

    function automatic bit below_edge(input longint x, input longint y,
                                      input logic [31:0] trig, input longint off);
        longint c;
        longint s;
        longint q;
        c = longint'($signed(trig[31:16]));
        s = longint'($signed(trig[15:0]));
        q = y * c + off;
        if (s >= 0) begin
            return x * s <= q;
        end
        return x * s >= q;
    endfunction

    function automatic logic [31:0] trig_of(input logic [11:0] tenths);
        real rad;
        int  c;
        int  s;
        rad = real'(angle_adj(tenths)) * 3.14159265358979 / 1800.0;
        c = int'($cos(rad) * 16384.0);
        s = int'($sin(rad) * 16384.0);
        return {c[15:0], s[15:0]};
    endfunction

    // Works out the spans of one row under the current register settings.
    task automatic predict_row_spans(input logic [7:0] row);
        longint r1, r2, tmp, orad, ir, ir2, or2, st, en;
        longint xs, xe, xe0, ylo, yhi, y, y2, x, len, d, cx, cy;
        bit     s180, e180, rev, f1, f2, scanning;
        span_t  found [MAX_SPANS];
        int     n;
        r1 = longint'(cur.rad_a);
        r2 = longint'(cur.rad_b);
        if (r1 < r2) begin
            tmp = r1;
            r1 = r2;
            r2 = tmp;
        end
        orad = radius_lim(r1[6:0]);
        ir = radius_lim(r2[6:0]) - 1;
        ir2 = ir * ir + ir;
        or2 = orad * orad + orad;
        st = longint'(angle_adj(cur.ang_s));
        en = longint'(angle_adj(cur.ang_e));
        s180 = (st >= 1800);
        e180 = (en < 1800);
        rev = (st + 1800 < en) || (en < st && st < en + 1800);
        cx = longint'(cur.center / SCREEN_SIZE);
        cy = longint'(cur.center % SCREEN_SIZE);
        xs = -orad;
        ylo = -orad;
        yhi = orad;
        xe0 = orad + 1;
        if (!rev) begin
            if ((en >= 2700 || en < 900) && (st >= 2700 || st < 900)) begin
                xs = 0;
            end else if (en < 2700 && en >= 900 && st < 2700 && st >= 900) begin
                xe0 = 1;
            end
            if (en >= 1800 && st >= 1800) begin
                yhi = 0;
            end else if (en < 1800 && st < 1800) begin
                ylo = 0;
            end
        end
        y = longint'($signed(row));
        if (y < ylo || y > yhi) begin
            return;
        end
        y2 = y * y;
        x = xs;
        xe = xe0;
        if (x < 0) begin
            while (x < 0 && x * x + y2 >= or2) begin
                x++;
            end
            if (xe0 != 1) begin
                xe = 1 - x;
            end
        end
        n = 0;
        len = 0;
        scanning = 1'b1;
        while (scanning) begin
            f1 = s180 != below_edge(x, y, cur.trig_s, HALF_Q14);
            f2 = e180 != below_edge(x, y, cur.trig_e, -HALF_Q14);
            d = x * x + y2;
            if (d >= ir2 && ((f1 && f2) || (rev && (f1 || f2))) && x != xe && d < or2) begin
                len++;
            end else begin
                if (len != 0) begin
                    if (n < MAX_SPANS) begin
                        found[n].sx = 11'(cx + x - len);
                        found[n].sy = 11'(cy + y);
                        found[n].len = 9'(len);
                        found[n].color = cur.color;
                        found[n].last = 1'b0;
                        n++;
                    end
                    len = 0;
                end
                if (d >= or2) begin
                    scanning = 1'b0;
                end else if (x < 0 && d < ir2) begin
                    x = -x;
                end
            end
            if (scanning) begin
                x++;
                scanning = (x <= xe);
            end
        end
        for (int i = 0; i < n; i++) begin
            found[i].last = (i == n - 1);
            pending_spans.push_back(found[i]);
        end
    endtask

    function automatic setting_t preset(input logic [1:0] k);
        case (k)
            2'd0: return '{18'h3FFFF, 7'd0, 7'd127, 12'd0, 12'd3600,
                           32'h4000_0000, 32'h4000_FFE3, 16'hA5A5};
            2'd1: return '{18'd51400, 7'd127, 7'd127, 12'd900, 12'd2700,
                           32'h001D_4000, 32'hFFE3_C000, 16'hFFFF};
            2'd2: return '{18'd0, 7'd40, 7'd10, 12'd450, 12'd3150,
                           32'h2D41_2D41, 32'h2D41_D2BF, 16'h0000};
            default: return '{18'd153620, 7'd20, 7'd0, 12'd0, 12'd900,
                              32'h4000_0000, 32'h001D_4000, 16'h5A5A};
        endcase
    endfunction

    function automatic setting_t random_setting(input bit odd);
        setting_t st;
        int       r;
        r = $urandom_range(0, 9);
        st.center = (r == 0) ? 18'd0 : (r == 1) ? 18'h3FFFF : 18'($urandom);
        st.rad_a = 7'($urandom_range(0, 127));
        st.rad_b = ($urandom_range(0, 5) == 0) ? st.rad_a : 7'($urandom_range(0, 127));
        if (odd) begin
            // Angles past a full turn and trig pairs that are not unit vectors.
            st.ang_s = 12'($urandom);
            st.ang_e = 12'($urandom);
            st.trig_s = $urandom;
            st.trig_e = $urandom;
        end else begin
            st.ang_s = ($urandom_range(0, 2) == 0) ? 12'(900 * $urandom_range(0, 3))
                                                   : 12'($urandom_range(0, 3599));
            st.ang_e = ($urandom_range(0, 2) == 0) ? 12'(900 * $urandom_range(1, 4))
                                                   : 12'($urandom_range(0, 3600));
            st.trig_s = trig_of(st.ang_s);
            st.trig_e = trig_of(st.ang_e);
        end
        r = $urandom_range(0, 5);
        st.color = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        return st;
    endfunction

    function automatic dir_entry_t dir_entry(input int k);
        case (k)
            0:  return '{DIR_ROW_KNOWN, 2'd0, 8'h00, 1'b1,
                         '{11'h7FF, 11'h000, 9'd3, 16'h0000, 1'b1}};
            1:  return '{DIR_ROW_KNOWN, 2'd0, 8'h01, 1'b1,
                         '{11'h000, 11'h001, 9'd1, 16'h0000, 1'b1}};
            2:  return '{DIR_ROW_KNOWN, 2'd0, 8'hFF, 1'b1,
                         '{11'h000, 11'h7FF, 9'd1, 16'h0000, 1'b1}};
            3:  return '{DIR_ROW_KNOWN, 2'd0, 8'h02, 1'b0, '0};
            4:  return '{DIR_ROW_KNOWN, 2'd0, 8'h7F, 1'b0, '0};
            5:  return '{DIR_ROW_KNOWN, 2'd0, 8'h80, 1'b0, '0};
            6:  return '{DIR_CFG, 2'd0, 8'h00, 1'b0, '0};
            7:  return '{DIR_ROW, 2'd0, 8'h81, 1'b0, '0};
            8:  return '{DIR_ROW, 2'd0, 8'h00, 1'b0, '0};
            9:  return '{DIR_ROW, 2'd0, 8'h7F, 1'b0, '0};
            10: return '{DIR_ROW, 2'd0, 8'hC0, 1'b0, '0};
            11: return '{DIR_CFG, 2'd1, 8'h00, 1'b0, '0};
            12: return '{DIR_ROW, 2'd0, 8'hCE, 1'b0, '0};
            13: return '{DIR_ROW, 2'd0, 8'h00, 1'b0, '0};
            14: return '{DIR_ROW, 2'd0, 8'h32, 1'b0, '0};
            15: return '{DIR_ROW, 2'd0, 8'h7F, 1'b0, '0};
            16: return '{DIR_CFG, 2'd2, 8'h00, 1'b0, '0};
            17: return '{DIR_ROW, 2'd0, 8'hE2, 1'b0, '0};
            18: return '{DIR_ROW, 2'd0, 8'h00, 1'b0, '0};
            19: return '{DIR_ROW, 2'd0, 8'h1E, 1'b0, '0};
            20: return '{DIR_ROW, 2'd0, 8'hD8, 1'b0, '0};
            21: return '{DIR_CFG, 2'd3, 8'h00, 1'b0, '0};
            22: return '{DIR_ROW, 2'd0, 8'hFB, 1'b0, '0};
            23: return '{DIR_ROW, 2'd0, 8'h00, 1'b0, '0};
            default: return '{DIR_ROW, 2'd0, 8'h0A, 1'b0, '0};
        endcase
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input setting_t st);
        write_reg(REG_CENTER_XY, 32'(st.center));
        write_reg(REG_OUTER_RADIUS, 32'(st.rad_a));
        write_reg(REG_INNER_RADIUS, 32'(st.rad_b));
        write_reg(REG_START_ANGLE, 32'(st.ang_s));
        write_reg(REG_END_ANGLE, 32'(st.ang_e));
        write_reg(REG_START_TRIG, st.trig_s);
        write_reg(REG_END_TRIG, st.trig_e);
        write_reg(REG_FILL_COLOR, 32'(st.color));
        i_cfg_we <= 1'b0;
        cur = st;
        settings_used++;
    endtask

    // Holds the sender back until every expected span has been seen, then settles if asked.
    task automatic drain(input bit settle);
        i_s_axis_tvalid <= 1'b0;
        while (pending_spans.size() != 0) begin
            @(posedge i_clk);
        end
        if (settle) begin
            repeat (SETTLE) @(posedge i_clk);
        end
    endtask

    task automatic send_row(input logic [7:0] row, input bit known,
                            input bit has_span, input span_t span);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= row;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        rows_sent++;
        if (!known) begin
            predict_row_spans(row);
        end else if (has_span) begin
            pending_spans.push_back(span);
        end
    endtask

    task automatic cmp_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            if (errors <= 50) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
            quiet = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.sx = o_m_axis_tdata[10:0];
                got.sy = o_m_axis_tdata[21:11];
                got.len = o_m_axis_tdata[30:22];
                got.color = o_m_axis_tdata[46:31];
                got.last = o_m_axis_tlast;
                spans_seen++;
                if (pending_spans.size() == 0) begin
                    errors++;
                    if (errors <= 50) begin
                        $display("%0t: unexpected word, expected none, actual 0x%0h last %0b",
                                 $time, o_m_axis_tdata, o_m_axis_tlast);
                    end
                end else begin
                    want = pending_spans.pop_front();
                    cmp_field("span_x", want.sx, got.sx);
                    cmp_field("span_y", want.sy, got.sy);
                    cmp_field("span_length", want.len, got.len);
                    cmp_field("span_color", want.color, got.color);
                    cmp_field("last_span", want.last, got.last);
                end
            end
            if ((o_m_axis_tvalid && i_m_axis_tready) ||
                (i_s_axis_tvalid && o_s_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no word has moved for %0d cycles, %0d spans outstanding",
                         $time, QUIET_LIMIT, pending_spans.size());
                $display("*** FAILED ***");
                $finish;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                i_m_axis_tready <= (stall_left == 0);
            end
        end
    end

    initial begin
        dir_entry_t ent;
        setting_t   st;
        longint     lim;
        logic [7:0] row;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_CENTER_XY;
        i_cfg_wdata = 32'd0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = 8'd0;
        i_m_axis_tready = 1'b0;
        gaps_on = 1'b1;
        errors = 0;
        rows_sent = 0;
        spans_seen = 0;
        settings_used = 0;
        cur = '{18'd0, 7'd1, 7'd1, 12'd0, 12'd3600, 32'h4000_0000, 32'h4000_FFE3, 16'h0000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_LEN; i++) begin
            ent = dir_entry(i);
            if (ent.kind == DIR_CFG) begin
                drain(1'b1);
                apply_setting(preset(ent.set_idx));
            end else begin
                send_row(ent.row, ent.kind == DIR_ROW_KNOWN, ent.has_span, ent.span);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain(1'b1);
            gaps_on = (ph % 3) != 2;
            st = random_setting(ph == 7 || $urandom_range(0, 5) == 0);
            apply_setting(st);
            lim = radius_lim((st.rad_a > st.rad_b) ? st.rad_a : st.rad_b);
            for (int k = 0; k < PHASE_ROWS; k++) begin
                if (ph == 4 && k == PHASE_ROWS / 2) begin
                    drain(1'b0);
                end
                if ($urandom_range(0, 99) < 85) begin
                    row = 8'($urandom_range(0, 2 * lim) - lim);
                end else begin
                    row = 8'($urandom_range(0, 255));
                end
                send_row(row, 1'b0, 1'b0, '0);
            end
        end
        drain(1'b1);

        $display("Sent %0d rows under %0d register settings and checked %0d span words.",
                 rows_sent, settings_used, spans_seen);
        $display("Settings covered full rings, half and quarter sectors, reflex sectors, ",
                 "clamped radii and unnormalised angle and trig values.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches found.", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
